// File: rtl/s5rp_pkg.sv
package s5rp_pkg;

   localparam int unsigned COUNT_W = 9;

   // parse status codes
   localparam logic [1:0] ST_WAIT = 2'd0;
   localparam logic [1:0] ST_DONE = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   // address kinds as reported
   localparam logic [1:0] AK_IPV4   = 2'd0;
   localparam logic [1:0] AK_DOMAIN = 2'd1;
   localparam logic [1:0] AK_IPV6   = 2'd2;

   // input item kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // wire values of the reply header
   localparam logic [7:0] SOCKS_VERSION  = 8'h05;
   localparam logic [7:0] MAX_REPLY_CODE = 8'h08;
   localparam logic [7:0] RSV_VALUE      = 8'h00;
   localparam logic [7:0] ATYP_IPV4      = 8'h01;
   localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
   localparam logic [7:0] ATYP_IPV6      = 8'h04;

   // byte positions in the reply
   localparam logic [COUNT_W-1:0] POS_VER  = 9'd0;
   localparam logic [COUNT_W-1:0] POS_REP  = 9'd1;
   localparam logic [COUNT_W-1:0] POS_RSV  = 9'd2;
   localparam logic [COUNT_W-1:0] POS_ATYP = 9'd3;
   localparam logic [COUNT_W-1:0] POS_DLEN = 9'd4;

   localparam logic [COUNT_W-1:0] LEN_MIN    = 9'd5;
   localparam logic [COUNT_W-1:0] LEN_IPV4   = 9'd10;
   localparam logic [COUNT_W-1:0] LEN_DOM0   = 9'd7;
   localparam logic [COUNT_W-1:0] LEN_IPV6   = 9'd22;
   localparam logic [COUNT_W-1:0] LEN_MAX    = 9'd262;

   localparam int unsigned RSP_DATA_W = 24;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [3:0]         code;
      logic [1:0]         akind;
      logic [7:0]         dlen;
      logic [1:0]         status;
   } state_type;

endpackage

// File: rtl/s5rp_step.sv
module s5rp_step (
   input  s5rp_pkg::state_type state_cur,
   input  logic                kind,
   input  logic [7:0]          data_byte,
   output s5rp_pkg::state_type state_nxt
);

   logic [s5rp_pkg::COUNT_W-1:0] count_inc;
   logic [s5rp_pkg::COUNT_W-1:0] total_len;
   logic                         bad;
   s5rp_pkg::state_type          upd;

   assign count_inc = state_cur.count + 9'd1;

   always_comb begin
      upd = state_cur;
      upd.count = count_inc;
      bad = 1'b0;
      case (state_cur.count)
         s5rp_pkg::POS_VER: begin
            bad = (data_byte != s5rp_pkg::SOCKS_VERSION);
         end
         s5rp_pkg::POS_REP: begin
            if (data_byte > s5rp_pkg::MAX_REPLY_CODE) begin
               bad = 1'b1;
            end else begin
               upd.code = data_byte[3:0];
            end
         end
         s5rp_pkg::POS_RSV: begin
            bad = (data_byte != s5rp_pkg::RSV_VALUE);
         end
         s5rp_pkg::POS_ATYP: begin
            case (data_byte)
               s5rp_pkg::ATYP_IPV4:   upd.akind = s5rp_pkg::AK_IPV4;
               s5rp_pkg::ATYP_DOMAIN: upd.akind = s5rp_pkg::AK_DOMAIN;
               s5rp_pkg::ATYP_IPV6:   upd.akind = s5rp_pkg::AK_IPV6;
               default:               bad = 1'b1;
            endcase
         end
         s5rp_pkg::POS_DLEN: begin
            if (state_cur.akind == s5rp_pkg::AK_DOMAIN) begin
               upd.dlen = data_byte;
            end
         end
         default: begin
         end
      endcase

      case (upd.akind)
         s5rp_pkg::AK_IPV4:   total_len = s5rp_pkg::LEN_IPV4;
         s5rp_pkg::AK_DOMAIN: total_len = s5rp_pkg::LEN_DOM0 + {1'b0, upd.dlen};
         default:             total_len = s5rp_pkg::LEN_IPV6;
      endcase

      if (bad) begin
         upd.status = s5rp_pkg::ST_ERR;
      end else if (count_inc >= s5rp_pkg::LEN_MIN && count_inc == total_len) begin
         upd.status = s5rp_pkg::ST_DONE;
      end

      // restart clears everything, finished replies ignore further bytes
      if (kind == s5rp_pkg::KIND_RESTART) begin
         state_nxt = '0;
      end else if (state_cur.status != s5rp_pkg::ST_WAIT) begin
         state_nxt = state_cur;
      end else begin
         state_nxt = upd;
      end
   end

endmodule

// File: rtl/socks5_reply_parser_unit.sv
// SOCKS5 connect-reply parser. Each req item is one reply byte (tuser = 0) or a
// restart (tuser = 1); each gives exactly one rsp item with the parse status
// (waiting, complete, error), the held reply code, the address kind and the
// count of reply bytes taken. Items pass an input register and a result
// register with the parse logic between them: one item per cycle sustained
// while rsp_tready holds, and the parser state loop closes in that single
// logic stage. After complete or error, bytes are ignored until restart.
module socks5_reply_parser_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // data_byte
   input  logic                               req_tuser,  // kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], reply_code[5:2], address_kind[7:6], bytes_seen[16:8], zero
   output logic [s5rp_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic                in_valid_ff, in_valid_in;
   logic                in_kind_ff;
   logic [7:0]          in_byte_ff;
   logic                out_valid_ff, out_valid_in;
   logic [s5rp_pkg::RSP_DATA_W-1:0] out_data_ff;
   s5rp_pkg::state_type state_ff, state_in, state_step;
   logic                move;
   logic                req_take;

   assign move       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || move;
   assign req_take   = req_tvalid && req_tready;

   s5rp_step u_step (
      .state_cur (state_ff),
      .kind      (in_kind_ff),
      .data_byte (in_byte_ff),
      .state_nxt (state_step)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !move);
      out_valid_in = move || (out_valid_ff && !rsp_tready);
      state_in     = move ? state_step : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      if (req_take) begin
         in_kind_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (move) begin
         out_data_ff <= {7'd0, state_step.count, state_step.akind,
                         state_step.code, state_step.status};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // a finished reply is frozen until a restart comes through
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      (move && in_kind_ff == s5rp_pkg::KIND_BYTE && state_ff.status != s5rp_pkg::ST_WAIT)
      |=> $stable(state_ff))
      else $error("finished reply state changed without restart");

   // completion only at a legal total length
   a_done_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.status == s5rp_pkg::ST_DONE) |->
      (state_ff.count >= s5rp_pkg::LEN_DOM0 && state_ff.count <= s5rp_pkg::LEN_MAX))
      else $error("reply complete at impossible length");

   // the byte count never runs past the longest reply
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      state_ff.count <= s5rp_pkg::LEN_MAX)
      else $error("byte count beyond longest reply");

   // restart item leaves the parser cleared
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (move && in_kind_ff == s5rp_pkg::KIND_RESTART) |=> (state_ff == '0))
      else $error("restart did not clear parser");

endmodule
